// File: src/tgad_pkg.sv
package tgad_pkg;

   localparam int PIXEL_BITS   = 32;
   localparam int COUNT_BITS   = 8;
   localparam int DIM_BITS     = 15;
   localparam int PRODUCT_BITS = 2 * DIM_BITS;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [1:0] CSR_SWAP_RED_BLUE   = 2'd1;
   localparam logic [1:0] CSR_FRAME_WIDTH     = 2'd2;
   localparam logic [1:0] CSR_FRAME_HEIGHT    = 2'd3;

   // one decoded pixel on its way from the parser to the counter
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [COUNT_BITS-1:0] repeat_count;
      logic                  raw_more;
   } tgad_entry_type;

endpackage

// File: src/tgad_front.sv
module tgad_front
   import tgad_pkg::*;
#(
   parameter int MAX_PIXEL_BYTES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 restart,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic [2:0]           bytes_per_pixel,
   input  logic                 swap_red_blue,
   output logic                 push,
   output tgad_entry_type       push_entry
);

   localparam int GATHER_BITS = 8 * MAX_PIXEL_BYTES;

   logic                   expect_ff, expect_in;
   logic                   run_ff, run_in;
   logic [COUNT_BITS-1:0]  left_ff, left_in;
   logic [1:0]             pos_ff, pos_in;
   logic [GATHER_BITS-1:0] gather_ff, gather_in;

   logic [2:0]             size;
   logic [1:0]             last_pos;
   logic [GATHER_BITS-1:0] pixel_full;
   logic [PIXEL_BITS-1:0]  pixel_wide;
   logic [PIXEL_BITS-1:0]  pixel_out;

   always_comb begin
      if (bytes_per_pixel == 3'd0) begin
         size = 3'd1;
      end else if (bytes_per_pixel > 3'(MAX_PIXEL_BYTES)) begin
         size = 3'(MAX_PIXEL_BYTES);
      end else begin
         size = bytes_per_pixel;
      end
   end

   assign last_pos = 2'(size - 3'd1);

   always_comb begin
      pixel_full = gather_ff;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
         if (pos_ff == 2'(k)) begin
            pixel_full[k*8 +: 8] = in_byte;
         end
      end
   end

   assign pixel_wide = PIXEL_BITS'(pixel_full);

   always_comb begin
      pixel_out = pixel_wide;
      if (swap_red_blue && size >= 3'd3) begin
         pixel_out = {pixel_wide[31:24], pixel_wide[7:0], pixel_wide[15:8], pixel_wide[23:16]};
      end
   end

   always_comb begin
      expect_in = expect_ff;
      run_in    = run_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      gather_in = gather_ff;
      push      = 1'b0;
      push_entry.pixel        = pixel_out;
      push_entry.repeat_count = run_ff ? left_ff : COUNT_BITS'(1);
      push_entry.raw_more     = !run_ff && (left_ff != COUNT_BITS'(1));

      if (accept) begin
         if (expect_ff) begin
            // run: header - 127, raw: header + 1; both are the low seven bits plus one
            run_in    = in_byte[7];
            left_in   = {1'b0, in_byte[6:0]} + COUNT_BITS'(1);
            expect_in = 1'b0;
            pos_in    = 2'd0;
            gather_in = '0;
         end else if (pos_ff == last_pos) begin
            push      = 1'b1;
            pos_in    = 2'd0;
            gather_in = '0;
            if (run_ff || left_ff == COUNT_BITS'(1)) begin
               expect_in = 1'b1;
            end
            left_in = run_ff ? '0 : left_ff - COUNT_BITS'(1);
         end else begin
            pos_in    = pos_ff + 2'd1;
            gather_in = pixel_full;
         end
      end

      if (restart) begin
         expect_in = 1'b1;
         run_in    = 1'b0;
         left_in   = '0;
         pos_in    = 2'd0;
         gather_in = '0;
         push      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= 1'b1;
         run_ff    <= 1'b0;
         left_ff   <= '0;
         pos_ff    <= 2'd0;
      end else begin
         expect_ff <= expect_in;
         run_ff    <= run_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
      end
      gather_ff <= reset ? '0 : gather_in;
   end

   a_header_consumed: assert property (@(posedge clock) disable iff (reset)
      (accept && expect_ff && !restart) |=> !expect_ff)
      else $error("header byte did not move parser to pixel bytes");

   a_pos_in_pixel: assert property (@(posedge clock) disable iff (reset)
      (!expect_ff && !restart && accept && pos_ff == last_pos) |=> (pos_ff == 2'd0))
      else $error("byte position not cleared after a full pixel");

endmodule

// File: src/tgad_queue.sv
module tgad_queue
   import tgad_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           flush,
   input  logic           push,
   input  tgad_entry_type push_entry,
   output logic           push_ready,
   output logic           pop_valid,
   input  logic           pop,
   output tgad_entry_type pop_entry
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   tgad_entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign push_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      if (flush) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_BITS'(QUEUE_DEPTH) && !pop) |-> !push)
      else $error("push into full queue");

endmodule

// File: src/tgad_back.sv
module tgad_back
   import tgad_pkg::*;
#(
   parameter int PIXEL_COUNT_BITS = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic                  load_total,
   input  logic [DIM_BITS-1:0]   frame_width,
   input  logic [DIM_BITS-1:0]   frame_height,
   input  logic                  q_valid,
   input  tgad_entry_type        q_entry,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIXEL_BITS-1:0] rsp_pixel_value,
   output logic [COUNT_BITS-1:0] rsp_repeat_count,
   output logic                  rsp_image_done,
   output logic                  rsp_run_clipped
);

   localparam int SAT_BITS = (PIXEL_COUNT_BITS > PRODUCT_BITS) ? PIXEL_COUNT_BITS : PRODUCT_BITS;

   logic [PRODUCT_BITS-1:0]     product;
   logic [SAT_BITS-1:0]         product_wide;
   logic [SAT_BITS-1:0]         cap_wide;
   logic [PIXEL_COUNT_BITS-1:0] total;

   logic [PIXEL_COUNT_BITS-1:0] remaining_ff, remaining_in;
   logic                        valid_ff, valid_in;
   logic [PIXEL_BITS-1:0]       pixel_ff, pixel_in;
   logic [COUNT_BITS-1:0]       count_ff, count_in;
   logic                        done_ff, done_in;
   logic                        clipped_ff, clipped_in;

   logic                        out_free;
   logic                        finished;
   logic                        emit;
   logic [PIXEL_COUNT_BITS-1:0] rep_ext;
   logic                        clip_run;
   logic [COUNT_BITS-1:0]       rep_eff;

   // pixel total, saturated to the counter width
   assign product      = PRODUCT_BITS'(frame_width) * PRODUCT_BITS'(frame_height);
   assign product_wide = SAT_BITS'(product);
   assign cap_wide     = SAT_BITS'({PIXEL_COUNT_BITS{1'b1}});
   assign total = (product_wide > cap_wide) ? cap_wide[PIXEL_COUNT_BITS-1:0]
                                            : product_wide[PIXEL_COUNT_BITS-1:0];

   assign out_free = !valid_ff || rsp_ready;
   // nothing left covers both a finished and an empty image: bytes are dropped
   assign finished = (remaining_ff == '0);
   assign q_pop    = q_valid && !load_total && !restart && (finished || out_free);
   assign emit     = q_pop && !finished;

   assign rep_ext  = PIXEL_COUNT_BITS'(q_entry.repeat_count);
   assign clip_run = (rep_ext > remaining_ff);
   assign rep_eff  = clip_run ? remaining_ff[COUNT_BITS-1:0] : q_entry.repeat_count;

   always_comb begin
      remaining_in = remaining_ff;
      valid_in     = valid_ff;
      pixel_in     = pixel_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      clipped_in   = clipped_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in     = 1'b1;
         pixel_in     = q_entry.pixel;
         count_in     = rep_eff;
         done_in      = (rep_ext >= remaining_ff);
         clipped_in   = clip_run || ((rep_ext >= remaining_ff) && q_entry.raw_more);
         remaining_in = remaining_ff - PIXEL_COUNT_BITS'(rep_eff);
      end
      if (load_total) begin
         remaining_in = total;
      end
      if (restart) begin
         valid_in     = 1'b0;
         remaining_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         valid_ff     <= valid_in;
      end
      pixel_ff   <= pixel_in;
      count_ff   <= count_in;
      done_ff    <= done_in;
      clipped_ff <= clipped_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_value  = pixel_ff;
   assign rsp_repeat_count = count_ff;
   assign rsp_image_done   = done_ff;
   assign rsp_run_clipped  = clipped_ff;

   a_clip_implies_done: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (!clipped_ff || done_ff))
      else $error("clipped result without image completion");

   a_done_empties_count: assert property (@(posedge clock) disable iff (reset)
      (emit && rep_ext >= remaining_ff && !load_total) |=> (remaining_ff == '0))
      else $error("image completed with pixels still counted as left");

endmodule

// File: src/tga_rle_pixel_decoder_unit.sv
// A pixel is held in the queue and then in the output register before its result appears.
// Throughput: one compressed byte per cycle while the queue has room; a pixel result every bytes_per_pixel bytes,
// plus one header byte per packet, set by the byte parser that takes one byte a cycle while req_ready is high.
// Reset (synchronous) and any register write restart decoding; in the cycle afterwards the
// pixel total is reloaded from width * height and no byte is accepted.
module tga_rle_pixel_decoder_unit
   import tgad_pkg::*;
#(
   parameter int MAX_PIXEL_BYTES  = 4,
   parameter int PIXEL_COUNT_BITS = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIXEL_BITS-1:0] rsp_pixel_value,
   output logic [COUNT_BITS-1:0] rsp_repeat_count,
   output logic                  rsp_image_done,
   output logic                  rsp_run_clipped,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [DIM_BITS-1:0]   csr_write_data
);

   logic [2:0]          bpp_ff;
   logic                swap_ff;
   logic [DIM_BITS-1:0] width_ff;
   logic [DIM_BITS-1:0] height_ff;
   logic                settle_ff;

   logic                restart;
   logic                accept;
   logic                push;
   logic                push_ready;
   tgad_entry_type      push_entry;
   logic                q_valid;
   logic                q_pop;
   tgad_entry_type      q_entry;

   assign restart   = csr_write_enable;
   assign req_ready = push_ready && !settle_ff;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff    <= 3'd4;
         swap_ff   <= 1'b1;
         width_ff  <= DIM_BITS'(1);
         height_ff <= DIM_BITS'(1);
         settle_ff <= 1'b1;
      end else begin
         settle_ff <= restart;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_BYTES_PER_PIXEL: bpp_ff    <= csr_write_data[2:0];
               CSR_SWAP_RED_BLUE:   swap_ff   <= csr_write_data[0];
               CSR_FRAME_WIDTH:     width_ff  <= csr_write_data;
               CSR_FRAME_HEIGHT:    height_ff <= csr_write_data;
               default:             bpp_ff    <= bpp_ff;
            endcase
         end
      end
   end

   tgad_front #(
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .restart         (restart),
      .accept          (accept),
      .in_byte         (req_in_byte),
      .bytes_per_pixel (bpp_ff),
      .swap_red_blue   (swap_ff),
      .push            (push),
      .push_entry      (push_entry)
   );

   tgad_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .flush      (restart),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_entry)
   );

   tgad_back #(
      .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .restart          (restart),
      .load_total       (settle_ff),
      .frame_width      (width_ff),
      .frame_height     (height_ff),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done),
      .rsp_run_clipped  (rsp_run_clipped)
   );

endmodule

// File: sim/tga_rle_pixel_decoder_unit_test.sv
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_unit_test
   import tgad_pkg::*;
();

   localparam int MAX_PIXEL_BYTES  = 4;
   localparam int PIXEL_COUNT_BITS = 30;
   localparam int RESULT_LATENCY   = 2;
   localparam int RANDOM_ITEMS     = 1400;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int PRINT_LIMIT      = 200;

   localparam logic [7:0] RUN_FLAG = 8'h80;
   localparam logic [7:0] RUN_BIAS = 8'd127;
   localparam logic [14:0] DIM_MAX = 15'd32767;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_BURSTY,
      READY_MOSTLY
   } ready_mode_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_value;
      logic [COUNT_BITS-1:0] repeat_count;
      logic                  image_done;
      logic                  run_clipped;
   } pixel_result_type;

   class pixel_scoreboard_type;
      logic [2:0]        bytes_per_pixel;
      logic              swap_red_blue;
      logic [14:0]       frame_width;
      logic [14:0]       frame_height;

      bit                want_header;
      bit                run_packet;
      logic [7:0]        pixels_left;
      logic [1:0]        byte_pos;
      logic [31:0]       gather;
      longint unsigned   emitted;
      bit                finished;

      pixel_result_type  expected_pixels[$];
      int                mismatches;

      function new();
         bytes_per_pixel = 3'd4;
         swap_red_blue   = 1'b1;
         frame_width     = 15'd1;
         frame_height    = 15'd1;
         mismatches      = 0;
         restart_decode();
      endfunction

      function void restart_decode();
         want_header = 1'b1;
         run_packet  = 1'b0;
         pixels_left = 8'd0;
         byte_pos    = 2'd0;
         gather      = 32'd0;
         emitted     = 0;
         finished    = 1'b0;
      endfunction

      function int unsigned pixel_size();
         int unsigned n;
         n = 32'(bytes_per_pixel);
         if (n < 1) n = 1;
         if (n > MAX_PIXEL_BYTES) n = MAX_PIXEL_BYTES;
         return n;
      endfunction

      function longint unsigned pixel_total();
         longint unsigned cap;
         longint unsigned t;
         cap = (longint'(1) << PIXEL_COUNT_BITS) - 1;
         t = longint'(frame_width) * longint'(frame_height);
         return (t > cap) ? cap : t;
      endfunction

      function bit stream_closed();
         return finished || (pixel_total() == 0);
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function void note_config(input logic [1:0] index, input logic [14:0] data);
         case (index)
            CSR_BYTES_PER_PIXEL: bytes_per_pixel = data[2:0];
            CSR_SWAP_RED_BLUE:   swap_red_blue   = data[0];
            CSR_FRAME_WIDTH:     frame_width     = data;
            CSR_FRAME_HEIGHT:    frame_height    = data;
         endcase
         restart_decode();
      endfunction

      // returns 1 when the byte was taken into decoding, 0 when dropped
      function bit note_byte(input logic [7:0] b);
         longint unsigned  total;
         longint unsigned  left;
         int unsigned      size;
         int unsigned      reps;
         logic [31:0]      pix;
         pixel_result_type res;
         total = pixel_total();
         size  = pixel_size();
         if (finished || total == 0) return 1'b0;
         if (want_header) begin
            run_packet  = b[7];
            pixels_left = b[7] ? b - RUN_BIAS : b + 8'd1;
            want_header = 1'b0;
            byte_pos    = 2'd0;
            gather      = 32'd0;
            return 1'b1;
         end
         gather   = gather | ({24'd0, b} << (8 * byte_pos));
         byte_pos = byte_pos + 2'd1;
         if (byte_pos != size[1:0]) return 1'b1;

         pix = gather;
         if (swap_red_blue && size >= 3)
            pix = {gather[31:24], gather[7:0], gather[15:8], gather[23:16]};
         gather   = 32'd0;
         byte_pos = 2'd0;

         res.run_clipped = 1'b0;
         res.image_done  = 1'b0;
         reps = run_packet ? 32'(pixels_left) : 32'd1;
         left = total - emitted;
         if (64'(reps) > left) begin
            reps = 32'(left);
            res.run_clipped = 1'b1;
         end
         emitted += 64'(reps);

         if (run_packet) begin
            pixels_left = 8'd0;
            want_header = 1'b1;
         end else begin
            pixels_left = pixels_left - 8'd1;
            if (pixels_left == 0) want_header = 1'b1;
         end

         if (emitted >= total) begin
            res.image_done = 1'b1;
            finished = 1'b1;
            // raw packet still holding pixels past the end of the image
            if (!run_packet && pixels_left != 0) res.run_clipped = 1'b1;
         end

         res.pixel_value  = pix;
         res.repeat_count = reps[7:0];
         expected_pixels.push_back(res);
         return 1'b1;
      endfunction

      task report_mismatch(input string what, input logic [31:0] got,
                           input logic [31:0] want);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      endtask

      task check_pixel(input pixel_result_type got);
         pixel_result_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected pixel", got.pixel_value, 32'd0);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_value !== want.pixel_value)
            report_mismatch("pixel_value", got.pixel_value, want.pixel_value);
         if (got.repeat_count !== want.repeat_count)
            report_mismatch("repeat_count", 32'(got.repeat_count), 32'(want.repeat_count));
         if (got.image_done !== want.image_done)
            report_mismatch("image_done", 32'(got.image_done), 32'(want.image_done));
         if (got.run_clipped !== want.run_clipped)
            report_mismatch("run_clipped", 32'(got.run_clipped), 32'(want.run_clipped));
      endtask
   endclass

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_in_byte      = 8'd0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [PIXEL_BITS-1:0] rsp_pixel_value;
   logic [COUNT_BITS-1:0] rsp_repeat_count;
   logic                  rsp_image_done;
   logic                  rsp_run_clipped;
   logic                  csr_write_enable = 1'b0;
   logic [1:0]            csr_index        = 2'd0;
   logic [DIM_BITS-1:0]   csr_write_data   = '0;

   pixel_scoreboard_type sb;
   int  consumed      = 0;
   int  burst_left    = 0;
   bit  gapless       = 1'b0;
   bit  long_hold_req = 1'b0;
   int  cycle_count   = 0;

   tga_rle_pixel_decoder_unit #(
      .MAX_PIXEL_BYTES  (MAX_PIXEL_BYTES),
      .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done),
      .rsp_run_clipped  (rsp_run_clipped),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL tga_rle_pixel_decoder_unit");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_pixel({rsp_pixel_value, rsp_repeat_count, rsp_image_done, rsp_run_clipped});
   end

   // receiver: own stall pattern, plus one long hold-off on request
   initial begin
      ready_mode_type mode;
      int mode_left;
      int tick;
      int held;
      mode      = READY_ALWAYS;
      mode_left = 0;
      tick      = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            held = 0;
            while (held < LONG_HOLD_CYCLES) begin
               @(negedge clock);
               held++;
            end
            long_hold_req = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            tick++;
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               READY_BURSTY: rsp_ready <= tick[2];
               default:      rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // all driving tasks start and end at a falling edge
   task automatic send_byte(input logic [7:0] b);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (sb.note_byte(b)) consumed++;
      @(negedge clock);
   endtask

   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = gapless ? 1000 : $urandom_range(1, 24);
         gap = gapless ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      send_byte(b);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // header bytes still in flight give no result, so allow the pipeline to empty
   task automatic settle();
      wait_results();
      repeat (RESULT_LATENCY + 3) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_config(input logic [2:0] bpp, input logic swap,
                               input logic [14:0] width, input logic [14:0] height,
                               input logic [3:0] which);
      logic [14:0] data[4];
      logic [11:0] junk12;
      logic [13:0] junk14;
      junk12 = 12'($urandom);
      junk14 = 14'($urandom);
      data[CSR_BYTES_PER_PIXEL] = {junk12, bpp};
      data[CSR_SWAP_RED_BLUE]   = {junk14, swap};
      data[CSR_FRAME_WIDTH]     = width;
      data[CSR_FRAME_HEIGHT]    = height;
      for (int i = 0; i < 4; i++) begin
         if (which[i]) begin
            csr_write_enable <= 1'b1;
            csr_index        <= i[1:0];
            csr_write_data   <= data[i];
            @(posedge clock);
            sb.note_config(i[1:0], data[i]);
            @(negedge clock);
         end
      end
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [7:0]  packet[$];
      logic [7:0]  next_byte;
      logic [2:0]  bpp;
      logic        swap;
      logic [14:0] width;
      logic [14:0] height;
      logic [3:0]  which;
      int          phase;
      int          budget;
      int          sent;
      int          pause_at;
      int          count;
      int          shape;
      bit          is_run;

      sb = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: 4-byte swapped pixels, 1x1 image; run of one, then a dropped byte
      push_byte(RUN_FLAG);
      push_byte(8'h11);
      push_byte(8'h22);
      push_byte(8'h33);
      push_byte(8'h44);
      push_byte(8'hFF);
      settle();

      // longest run cut to a 2-pixel image
      write_config(3'd3, 1'b1, 15'd2, 15'd1, 4'hF);
      push_byte(8'hFF);
      push_byte(8'hA1);
      push_byte(8'hB2);
      push_byte(8'hC3);
      settle();

      // byte size 0 acts as 1; longest raw packet overruns a 3-pixel image
      write_config(3'd0, 1'b0, 15'd3, 15'd1, 4'hF);
      push_byte(8'h7F);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'hA5);
      settle();

      // oversized byte count, empty image: everything dropped
      write_config(3'd7, 1'b0, 15'd0, 15'd5, 4'hF);
      push_byte(8'h00);
      push_byte(8'h81);
      settle();

      // 2-byte pixels ignore the swap; largest image
      write_config(3'd2, 1'b1, DIM_MAX, DIM_MAX, 4'hF);
      push_byte(8'h01);
      push_byte(8'h5A);
      push_byte(8'hC3);
      push_byte(8'h3C);
      push_byte(8'hA5);
      push_byte(8'h80);
      push_byte(8'hF0);
      push_byte(8'h0F);
      settle();

      consumed = 0;
      phase    = 0;
      while (consumed < RANDOM_ITEMS) begin
         if (phase == 0) begin
            bpp    = 3'd1;
            swap   = 1'($urandom_range(0, 1));
            width  = DIM_MAX;
            height = DIM_MAX;
            which  = 4'hF;
         end else begin
            if ($urandom_range(0, 4) != 0) bpp = 3'($urandom_range(1, 4));
            else bpp = 3'($urandom_range(5, 8));
            swap  = 1'($urandom_range(0, 1));
            shape = $urandom_range(0, 9);
            if (shape < 7) begin
               width  = 15'($urandom_range(1, 24));
               height = 15'($urandom_range(1, 6));
            end else if (shape == 7) begin
               width  = $urandom_range(0, 1) ? DIM_MAX : 15'($urandom_range(1, 32767));
               height = $urandom_range(0, 1) ? DIM_MAX : 15'($urandom_range(1, 4));
            end else if (shape == 8) begin
               width  = 15'd1;
               height = 15'd1;
            end else begin
               width  = $urandom_range(0, 1) ? 15'd0 : 15'($urandom_range(1, 32767));
               height = (width == 0) ? 15'($urandom_range(0, 32767)) : 15'd0;
            end
            which = ($urandom_range(0, 3) != 0) ? 4'hF : 4'($urandom_range(1, 15));
         end
         write_config(bpp, swap, width, height, which);

         gapless  = ($urandom_range(0, 3) == 0);
         budget   = sb.stream_closed() ? 3 : $urandom_range(30, 160);
         pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ? budget / 2 : -1;
         if (phase == 0) long_hold_req = 1'b1;
         sent = 0;

         while (sent < budget && !sb.stream_closed()) begin
            packet.delete();
            if ($urandom_range(0, 9) == 0) begin
               // stray byte, shifts packet alignment
               next_byte = 8'($urandom);
               packet.push_back(next_byte);
            end else begin
               count  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 128)
                                                    : $urandom_range(1, 8);
               is_run = 1'($urandom_range(0, 1));
               next_byte = 8'(count - 1);
               packet.push_back(is_run ? (RUN_FLAG | next_byte) : next_byte);
               repeat ((is_run ? 1 : count) * sb.pixel_size()) begin
                  next_byte = 8'($urandom);
                  packet.push_back(next_byte);
               end
            end
            while (packet.size() != 0 && sent < budget && !sb.stream_closed()) begin
               if (sent == pause_at) begin
                  wait_results();
                  burst_left = 0;
               end
               push_byte(packet.pop_front());
               sent++;
            end
         end

         // bytes past the end of the image are dropped
         repeat ($urandom_range(0, 2)) begin
            next_byte = 8'($urandom);
            push_byte(next_byte);
         end
         settle();
         phase++;
      end

      settle();
      repeat (RESULT_LATENCY + 8) @(negedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch("pixels never produced", 32'(sb.pending()), 32'd0);
      if (sb.mismatches == 0) begin
         $display("PASS tga_rle_pixel_decoder_unit");
      end else begin
         $display("FAIL tga_rle_pixel_decoder_unit");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/tgad_pkg.sv
src/tgad_front.sv
src/tgad_queue.sv
src/tgad_back.sv
src/tga_rle_pixel_decoder_unit.sv
sim/tga_rle_pixel_decoder_unit_test.sv
